### design/tp20_receive_reassembler_defines.svh
// ----------------------------------------------------------------------------
// TP2.0 receive reassembler assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TP20_RECEIVE_REASSEMBLER_DEFINES_SVH
`define TP20_RECEIVE_REASSEMBLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TP20_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tp20 assertion failed");
`define TP20_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tp20 assertion failed");
`else
`define TP20_ASSERT(label, prop)
`define TP20_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/tp20rx_pkg.sv
// ----------------------------------------------------------------------------
// tp20rx_pkg
// Types, command bytes and status codes of the TP2.0 receive reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package tp20rx_pkg;

  localparam logic [7:0]  CMD_TEST    = 8'hA3;
  localparam logic [7:0]  CMD_CLOSE_A = 8'hA8;
  localparam logic [7:0]  CMD_CLOSE_B = 8'hA4;
  localparam logic [15:0] LEN_MASK    = 16'h7FFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_OP    = 3'd1;
  localparam logic [2:0] ST_BAD_SEQ   = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_TEST      = 3'd4;
  localparam logic [2:0] ST_CLOSED    = 3'd5;

  typedef struct packed {
    logic [7:0]  header;
    logic [55:0] payload;
    logic [3:0]  length;
    logic        new_channel;
  } frame_t;

  typedef struct packed {
    logic        expect_first;
    logic [3:0]  rx_sequence;
    logic [15:0] announced_length;
    logic [15:0] received_count;
  } rx_state_t;

  typedef struct packed {
    logic [55:0] data_bytes;
    logic [2:0]  data_count;
    logic        first_of_message;
    logic        last_of_message;
    logic        ack_request;
    logic [3:0]  ack_sequence;
    logic [15:0] message_length;
    logic [2:0]  status;
    logic        underrun;
    logic        overrun;
  } result_t;

endpackage

`default_nettype wire

### design/tp20rx_decode.sv
// ----------------------------------------------------------------------------
// tp20rx_decode
// Frame decode: command bytes, opcode and sequence checks, first-frame length,
// payload extraction and the next channel state, all in one combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tp20rx_decode (
  input  wire  tp20rx_pkg::frame_t    frame,
  input  wire                         mask_length_msb,
  input  wire  tp20rx_pkg::rx_state_t state,
  output tp20rx_pkg::rx_state_t       state_nxt,
  output tp20rx_pkg::result_t         result
);
  import tp20rx_pkg::*;

  logic [3:0]  flen;
  logic [3:0]  opcode;
  logic [3:0]  seq;
  logic [3:0]  seq_inc;
  logic [2:0]  count;
  logic [55:0] data_raw;
  logic [55:0] byte_mask;
  logic [15:0] len_raw;
  logic [15:0] ann_len;
  logic [15:0] base_count;
  logic [16:0] sum;
  logic [15:0] new_count;

  always_comb begin
    flen = frame.length;
    if (flen == 4'd0) begin
      flen = 4'd1;
    end else if (flen > 4'd8) begin
      flen = 4'd8;
    end
  end

  assign opcode  = frame.header[7:4];
  assign seq     = frame.header[3:0];
  assign seq_inc = state.rx_sequence + 4'd1;

  assign len_raw = frame.payload[55:40];
  assign ann_len = state.expect_first
                   ? (mask_length_msb ? (len_raw & LEN_MASK) : len_raw)
                   : state.announced_length;

  assign count      = state.expect_first ? 3'(flen - 4'd3) : 3'(flen - 4'd1);
  assign data_raw   = state.expect_first ? {frame.payload[39:0], 16'h0000} : frame.payload;
  assign byte_mask  = ~({56{1'b1}} >> {count, 3'b000});
  assign base_count = state.expect_first ? 16'd0 : state.received_count;
  assign sum        = {1'b0, base_count} + {14'd0, count};
  assign new_count  = sum[16] ? COUNT_MAX : sum[15:0];

  always_comb begin
    state_nxt = state;
    result    = '0;
    if (frame.new_channel) begin
      state_nxt = '0;
      state_nxt.expect_first = 1'b1;
    end else if (frame.header == CMD_TEST) begin
      result.status = ST_TEST;
    end else if (frame.header == CMD_CLOSE_A || frame.header == CMD_CLOSE_B) begin
      state_nxt.expect_first     = 1'b1;
      state_nxt.announced_length = '0;
      state_nxt.received_count   = '0;
      result.status = ST_CLOSED;
    end else if (state.expect_first && flen < 4'd3) begin
      result.status = ST_SHORT;
    end else if (opcode > 4'd3) begin
      state_nxt.expect_first     = 1'b1;
      state_nxt.announced_length = '0;
      state_nxt.received_count   = '0;
      result.status = ST_BAD_OP;
    end else if (seq != state.rx_sequence) begin
      state_nxt.rx_sequence      = seq_inc;
      state_nxt.expect_first     = 1'b1;
      state_nxt.announced_length = '0;
      state_nxt.received_count   = '0;
      result.status = ST_BAD_SEQ;
    end else begin
      state_nxt.rx_sequence      = seq_inc;
      state_nxt.announced_length = ann_len;
      state_nxt.received_count   = new_count;
      state_nxt.expect_first     = opcode[0];
      result.data_bytes       = data_raw & byte_mask;
      result.data_count       = count;
      result.first_of_message = state.expect_first;
      result.last_of_message  = opcode[0];
      result.ack_request      = ~opcode[1];
      result.ack_sequence     = opcode[1] ? 4'd0 : seq_inc;
      result.message_length   = ann_len;
      result.status           = ST_OK;
      result.overrun          = new_count > ann_len;
      result.underrun         = opcode[0] & (new_count < ann_len);
    end
  end

endmodule

`default_nettype wire

### design/tp20_receive_reassembler.sv
// ----------------------------------------------------------------------------
// tp20_receive_reassembler
// Receives one TP2.0 CAN frame per transaction and reports its message data,
// sequence checks, length accounting and ACK requests.
// ----------------------------------------------------------------------------
// Accepts one frame per clock cycle while in_ready is high and returns exactly
// one result per frame. The frame is captured in an input register when
// accepted, is decoded against the channel state in one combinational pass,
// and enters the result register once it is free. The channel state (sequence
// counter, first-frame flag, announced length, received byte count) updates as
// each frame enters the result register, so consecutive frames chain with no
// bubble. in_ready drops only while a result is held by out_ready low and the
// input register is full. The user must write the mask_length_msb register via
// the cfg port only while idle; the block does not check.
`default_nettype none

`include "tp20_receive_reassembler_defines.svh"

module tp20_receive_reassembler (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_mask_length_msb,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_frame_header,
  input  wire  [55:0] in_frame_payload,
  input  wire  [3:0]  in_frame_length,
  input  wire         in_new_channel,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [55:0] out_data_bytes,
  output logic [2:0]  out_data_count,
  output logic        out_first_of_message,
  output logic        out_last_of_message,
  output logic        out_ack_request,
  output logic [3:0]  out_ack_sequence,
  output logic [15:0] out_message_length,
  output logic [2:0]  out_status,
  output logic        out_underrun,
  output logic        out_overrun
);
  import tp20rx_pkg::*;

  logic      mask_r;
  logic      in_valid_r;
  frame_t    frame_r;
  rx_state_t state_r;
  rx_state_t state_nxt;
  result_t   result_nxt;
  result_t   result_r;
  logic      out_valid_r;
  logic      advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;

  tp20rx_decode u_decode (
    .frame           (frame_r),
    .mask_length_msb (mask_r),
    .state           (state_r),
    .state_nxt       (state_nxt),
    .result          (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_mask_length_msb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r <= '{header:      in_frame_header,
                   payload:     in_frame_payload,
                   length:      in_frame_length,
                   new_channel: in_new_channel};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{expect_first: 1'b1, rx_sequence: 4'd0,
                   announced_length: 16'd0, received_count: 16'd0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data_bytes       = result_r.data_bytes;
  assign out_data_count       = result_r.data_count;
  assign out_first_of_message = result_r.first_of_message;
  assign out_last_of_message  = result_r.last_of_message;
  assign out_ack_request      = result_r.ack_request;
  assign out_ack_sequence     = result_r.ack_sequence;
  assign out_message_length   = result_r.message_length;
  assign out_status           = result_r.status;
  assign out_underrun         = result_r.underrun;
  assign out_overrun          = result_r.overrun;

  `TP20_ASSERT(a_err_no_data,
    !(out_valid && out_status != ST_OK) || (out_data_count == 3'd0 && !out_ack_request))
  `TP20_ASSERT(a_underrun_on_last, !(out_valid && out_underrun) || out_last_of_message)
  `TP20_ASSERT(a_stall_only_on_hold, in_ready || (out_valid && !out_ready))
  `TP20_ASSERT_NEXT(a_first_clears_expect,
    advance && !frame_r.new_channel && result_nxt.status == ST_OK
      && !result_nxt.last_of_message,
    !state_r.expect_first)

endmodule

`default_nettype wire
